FILE: sv/sqmm_pkg.sv
package sqmm_pkg;

  localparam int IDX_W   = 6;
  localparam int VAL_W   = 32;
  localparam int SIZE_W  = 7;
  localparam int SUM_W   = 64;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // Word index of the matrix size register (paddr[2]).
  localparam logic REG_MATRIX_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_WRITE_LEFT  = 2'd0,
    OP_WRITE_RIGHT = 2'd1,
    OP_COMPUTE     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_CALC = 2'd2,
    CMD_ZERO = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [VAL_W-1:0]   value;
  } cmd_t;

endpackage

FILE: sv/square_integer_matrix_multiply.sv
// Square integer matrix multiply, one element of C = A x B per compute word.
// Input channel: a word is taken at a rising edge where start is high and
// busy is low. Operation 0 stores element_value_i into A at row/column,
// operation 1 into B, operation 2 asks for C[row][column]; code 3 is dropped.
// Stores outside the matrices are dropped; a compute outside them returns 0.
// Result channel: result_valid_o is high for one cycle with product_value_o,
// the wrapped 64-bit dot product. The receiver cannot stall it.
// Words pass a two-entry queue to the execution side, so busy rises only
// when that queue is full. A store is written to its matrix RAM as it is popped;
// a compute holds the execution side for n multiply-accumulates, one per cycle
// through the single read port of each matrix RAM, and its result is registered
// once the last product is accumulated (n = matrix size, capped at MAX_DIM).
// Configuration: APB register 0 (byte address 0) holds the matrix size n,
// 64 after reset. Write it only while no word is in flight.
// Reset clears the control state and returns the size register to 64;
// matrix contents are undefined until written.
module square_integer_matrix_multiply #(
  parameter int MAX_DIM   = 64,
  parameter int ELEM_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         operation_i,
  input  logic [sqmm_pkg::IDX_W-1:0]         row_index_i,
  input  logic [sqmm_pkg::IDX_W-1:0]         column_index_i,
  input  logic signed [sqmm_pkg::VAL_W-1:0]  element_value_i,
  output logic                               result_valid_o,
  output logic signed [sqmm_pkg::SUM_W-1:0]  product_value_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sqmm_pkg::APB_AW-1:0]        paddr,
  input  logic [sqmm_pkg::APB_DW-1:0]        pwdata,
  output logic [sqmm_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import sqmm_pkg::*;

  localparam int CntW = $clog2(MAX_DIM + 1);

  logic [SIZE_W-1:0] size_q;
  logic [CntW-1:0]   n_eff;
  logic              q_push, q_pop, q_full, q_empty;
  cmd_t              q_in, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MATRIX_SIZE) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (int'(size_q) > MAX_DIM) begin
      n_eff = CntW'(MAX_DIM);
    end else begin
      n_eff = CntW'(size_q);
    end
    prdata = (paddr[2] == REG_MATRIX_SIZE) ? APB_DW'(size_q) : '0;
  end

  assign pready = 1'b1;
  assign busy   = q_full;

  sqmm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .start_i     (start),
    .full_i      (q_full),
    .operation_i (operation_i),
    .row_i       (row_index_i),
    .col_i       (column_index_i),
    .value_i     (element_value_i),
    .push_o      (q_push),
    .cmd_o       (q_in)
  );

  sqmm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  sqmm_back #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .n_i             (n_eff),
    .head_i          (q_head),
    .empty_i         (q_empty),
    .pop_o           (q_pop),
    .result_valid_o  (result_valid_o),
    .product_value_o (product_value_o)
  );

endmodule

FILE: sv/sqmm_front.sv
module sqmm_front #(
  parameter int MAX_DIM = 64
) (
  input  logic                       start_i,
  input  logic                       full_i,
  input  logic [1:0]                 operation_i,
  input  logic [sqmm_pkg::IDX_W-1:0] row_i,
  input  logic [sqmm_pkg::IDX_W-1:0] col_i,
  input  logic [sqmm_pkg::VAL_W-1:0] value_i,
  output logic                       push_o,
  output sqmm_pkg::cmd_t             cmd_o
);
  import sqmm_pkg::*;

  logic in_range;
  logic accept;

  always_comb begin
    in_range  = (int'(row_i) < MAX_DIM) && (int'(col_i) < MAX_DIM);
    accept    = start_i && !full_i;
    push_o    = 1'b0;
    cmd_o.row   = row_i;
    cmd_o.col   = col_i;
    cmd_o.value = value_i;
    cmd_o.kind  = CMD_ZERO;
    unique case (op_e'(operation_i))
      OP_WRITE_LEFT: begin
        cmd_o.kind = CMD_WR_A;
        push_o     = accept && in_range;
      end
      OP_WRITE_RIGHT: begin
        cmd_o.kind = CMD_WR_B;
        push_o     = accept && in_range;
      end
      OP_COMPUTE: begin
        // A compute outside the storage still returns one word, holding zero.
        cmd_o.kind = in_range ? CMD_CALC : CMD_ZERO;
        push_o     = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/sqmm_queue.sv
module sqmm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sqmm_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output sqmm_pkg::cmd_t head_o
);
  import sqmm_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

endmodule

FILE: sv/sqmm_ram.sv
module sqmm_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/sqmm_back.sv
module sqmm_back #(
  parameter int MAX_DIM   = 64,
  parameter int ELEM_BITS = 32,
  localparam int CntW  = $clog2(MAX_DIM + 1),
  localparam int AddrW = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [CntW-1:0]                   n_i,
  input  sqmm_pkg::cmd_t                    head_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              result_valid_o,
  output logic signed [sqmm_pkg::SUM_W-1:0] product_value_o
);
  import sqmm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               k_q, n_q;
  logic [AddrW-1:0]              a_addr_q, b_addr_q;
  logic [AddrW-1:0]              wr_addr, row_base;
  logic                          rd_vld_q, prod_vld_q, res_vld_q;
  logic signed [SUM_W-1:0]       prod_q;
  logic [SUM_W-1:0]              acc_q, res_q;
  logic [ELEM_BITS-1:0]          a_rd, b_rd;
  logic signed [2*ELEM_BITS-1:0] mul;
  logic                          issue, finish, we_a, we_b;

  always_comb begin
    row_base = AddrW'(head_i.row) * AddrW'(MAX_DIM);
    wr_addr  = row_base + AddrW'(head_i.col);
    pop_o    = (state_q == ST_IDLE) && !empty_i;
    we_a     = pop_o && (head_i.kind == CMD_WR_A);
    we_b     = pop_o && (head_i.kind == CMD_WR_B);
    issue    = (state_q == ST_RUN) && (k_q != n_q);
    // All reads issued and the multiply pipe empty: the sum is complete.
    finish   = (state_q == ST_RUN) && (k_q == n_q) && !rd_vld_q && !prod_vld_q;
    mul      = (2*ELEM_BITS)'($signed(a_rd)) * (2*ELEM_BITS)'($signed(b_rd));
    state_d  = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o && (head_i.kind == CMD_CALC || head_i.kind == CMD_ZERO)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  sqmm_ram #(
    .Width (ELEM_BITS),
    .Depth (MAX_DIM * MAX_DIM)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (wr_addr),
    .wdata_i (head_i.value[ELEM_BITS-1:0]),
    .raddr_i (a_addr_q),
    .rdata_o (a_rd)
  );

  sqmm_ram #(
    .Width (ELEM_BITS),
    .Depth (MAX_DIM * MAX_DIM)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (wr_addr),
    .wdata_i (head_i.value[ELEM_BITS-1:0]),
    .raddr_i (b_addr_q),
    .rdata_o (b_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      res_vld_q  <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      n_q      <= (head_i.kind == CMD_CALC) ? n_i : '0;
      k_q      <= '0;
      a_addr_q <= row_base;
      b_addr_q <= AddrW'(head_i.col);
      acc_q    <= '0;
    end else begin
      if (issue) begin
        k_q      <= k_q + CntW'(1);
        a_addr_q <= a_addr_q + AddrW'(1);
        b_addr_q <= b_addr_q + AddrW'(MAX_DIM);
      end
      if (prod_vld_q) begin
        acc_q <= acc_q + prod_q;
      end
    end
    if (rd_vld_q) begin
      prod_q <= SUM_W'(mul);
    end
    if (finish) begin
      res_q <= acc_q;
    end
  end

  assign result_valid_o  = res_vld_q;
  assign product_value_o = res_q;

endmodule

FILE: sv/sqmm_checker.sv
module sqmm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation_i,
  input logic       result_valid_o
);
  import sqmm_pkg::*;

  // Compute words taken whose result word has not yet been shown.
  logic [2:0] pend_q, pend_d;
  logic       take_calc;

  always_comb begin
    take_calc = start && !busy && (op_e'(operation_i) == OP_COMPUTE);
    pend_d    = pend_q;
    if (take_calc && !result_valid_o) begin
      pend_d = pend_q + 3'd1;
    end else if (!take_calc && result_valid_o) begin
      pend_d = pend_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  a_result_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (pend_q != 3'd0))
    else $error("result word without a pending compute");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more compute words in flight than the queue and engine hold");

  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a word being taken");

endmodule

bind square_integer_matrix_multiply sqmm_checker u_sqmm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .operation_i    (operation_i),
  .result_valid_o (result_valid_o)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sqmm_pkg::*;

  localparam int          MAX_N       = 64;
  localparam int          SETTLE      = 80;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [31:0] INT_MIN     = 32'h8000_0000;
  localparam logic [31:0] INT_MAX     = 32'h7fff_ffff;
  localparam logic [APB_AW-1:0] SIZE_ADDR = {REG_MATRIX_SIZE, 2'b00};

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               operation_i;
  logic [IDX_W-1:0]         row_index_i;
  logic [IDX_W-1:0]         column_index_i;
  logic signed [VAL_W-1:0]  element_value_i;
  logic                     result_valid_o;
  logic signed [SUM_W-1:0]  product_value_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;

  // Shadow copy of the block: both matrices, which entries hold data, and the size.
  int          left_store  [0:4095];
  int          right_store [0:4095];
  bit          left_written  [0:4095];
  bit          right_written [0:4095];
  logic [6:0]  size_cfg;

  longint      pending_products[$];
  longint      oldest_product;
  int          error_count;
  int          words_sent;
  bit          no_idle;

  square_integer_matrix_multiply i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .row_index_i     (row_index_i),
    .column_index_i  (column_index_i),
    .element_value_i (element_value_i),
    .result_valid_o  (result_valid_o),
    .product_value_o (product_value_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int effective_size();
    return (size_cfg > MAX_N) ? MAX_N : int'(size_cfg);
  endfunction

  function automatic longint dot_row_col(logic [5:0] row, logic [5:0] col);
    longint acc;
    int     n;
    acc = 0;
    n = effective_size();
    for (int k = 0; k < n; k++) begin
      acc += longint'(left_store[{row, 6'(k)}]) * longint'(right_store[{6'(k), col}]);
    end
    return acc;
  endfunction

  // Applies one accepted word to the shadow state and queues its product, if any.
  function automatic void apply_word(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                     logic [31:0] value);
    if (op == OP_WRITE_LEFT) begin
      left_store[{row, col}] = int'(value);
      left_written[{row, col}] = 1'b1;
    end else if (op == OP_WRITE_RIGHT) begin
      right_store[{row, col}] = int'(value);
      right_written[{row, col}] = 1'b1;
    end else if (op == OP_COMPUTE) begin
      pending_products.push_back(dot_row_col(row, col));
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Start stays high after a word unless a gap follows, so back-to-back words
  // never see start lowered and raised in the same step.
  task automatic send_word(input logic [1:0] op, input logic [5:0] row, input logic [5:0] col,
                           input logic [31:0] value);
    int gap;
    @(negedge clk_i);
    start           <= 1'b1;
    operation_i     <= op;
    row_index_i     <= row;
    column_index_i  <= col;
    element_value_i <= value;
    do @(posedge clk_i); while (busy);
    apply_word(op, row, col, value);
    if (op != OP_UNUSED) words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_products.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic write, input logic [APB_AW-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_size_reg();
    logic [31:0] rdata;
    apb_access(1'b0, SIZE_ADDR, '0, rdata);
    if (rdata[6:0] !== size_cfg) begin
      $error("matrix_size readback: expected %0d, got %0d", size_cfg, rdata[6:0]);
      error_count++;
    end
  endtask

  // The upper bits of the write data are not part of the register.
  task automatic set_size(input logic [6:0] n, input logic [24:0] junk);
    logic [31:0] rdata;
    drain_and_settle();
    apb_access(1'b1, SIZE_ADDR, {junk, n}, rdata);
    size_cfg = n;
    check_size_reg();
  endtask

  // Loads whatever row of A and column of B the product still needs, reloads some at random, then asks for it.
  task automatic compute_with_operands(input logic [5:0] row, input logic [5:0] col);
    int n;
    n = effective_size();
    for (int k = 0; k < n; k++) begin
      if (!left_written[{row, 6'(k)}] || $urandom_range(0, 9) == 0)
        send_word(OP_WRITE_LEFT, row, 6'(k), pick_value());
      if (!right_written[{6'(k), col}] || $urandom_range(0, 9) == 0)
        send_word(OP_WRITE_RIGHT, 6'(k), col, pick_value());
    end
    send_word(OP_COMPUTE, row, col, $urandom);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_products.size() == 0) begin
        $error("product_value: expected none, got %0d", product_value_o);
        error_count++;
      end else begin
        oldest_product = pending_products.pop_front();
        if (product_value_o !== oldest_product) begin
          $error("product_value: expected %0d, got %0d", oldest_product, product_value_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_register_access();
    check_size_reg();
    set_size(7'd1, 25'($urandom));
  endtask

  task automatic test_extreme_elements();
    send_word(OP_WRITE_LEFT, 6'd0, 6'd0, INT_MIN);
    send_word(OP_WRITE_RIGHT, 6'd0, 6'd0, INT_MIN);
    send_word(OP_COMPUTE, 6'd0, 6'd0, '0);
    send_word(OP_WRITE_LEFT, 6'd63, 6'd0, INT_MAX);
    send_word(OP_WRITE_RIGHT, 6'd0, 6'd63, 32'hffff_ffff);
    // Rows and columns past the size in use still address stored entries.
    send_word(OP_COMPUTE, 6'd63, 6'd63, INT_MAX);
    send_word(OP_COMPUTE, 6'd0, 6'd63, '0);
    send_word(OP_COMPUTE, 6'd63, 6'd0, '0);
  endtask

  task automatic test_unused_operation();
    send_word(OP_UNUSED, 6'd0, 6'd0, 32'd7);
    send_word(OP_UNUSED, 6'd63, 6'd63, INT_MIN);
    send_word(OP_COMPUTE, 6'd0, 6'd0, '0);
  endtask

  task automatic test_sum_wraparound();
    set_size(7'd4, '0);
    for (int k = 0; k < 4; k++) begin
      send_word(OP_WRITE_LEFT, 6'd1, 6'(k), INT_MIN);
      send_word(OP_WRITE_RIGHT, 6'(k), 6'd1, INT_MIN);
    end
    send_word(OP_COMPUTE, 6'd1, 6'd1, '0);
  endtask

  task automatic test_size_zero();
    set_size(7'd0, '0);
    send_word(OP_COMPUTE, 6'd17, 6'd42, '0);
    send_word(OP_COMPUTE, 6'd63, 6'd63, '0);
  endtask

  task automatic test_size_saturation();
    set_size(7'd127, '1);
    compute_with_operands(6'd63, 6'd0);
    compute_with_operands(6'd0, 6'd63);
  endtask

  task automatic test_random_traffic();
    logic [6:0] sizes [0:7] = '{7'd3, 7'd1, 7'd8, 7'd64, 7'd2, 7'd100, 7'd5, 7'd0};
    int         budget;
    int         first;
    int         pick;
    int         n;
    logic [5:0] row;
    logic [5:0] col;
    for (int p = 0; p < 8; p++) begin
      set_size(sizes[p], 25'($urandom));
      no_idle = (p == 2);
      n = effective_size();
      budget = (n == MAX_N) ? 10 : 18;
      first = words_sent;
      while (words_sent - first < budget) begin
        pick = $urandom_range(0, 99);
        if (n == MAX_N) begin
          // Full-size products reuse the outer rows and columns loaded earlier.
          row = $urandom_range(0, 1) ? 6'd63 : 6'd0;
          col = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        end else if (n > 0 && $urandom_range(0, 1)) begin
          row = 6'($urandom_range(0, n - 1));
          col = 6'($urandom_range(0, n - 1));
        end else begin
          row = 6'($urandom_range(0, 63));
          col = 6'($urandom_range(0, 63));
        end
        if (pick < 60)
          compute_with_operands(row, col);
        else if (pick < 75)
          send_word(OP_WRITE_LEFT, row, col, pick_value());
        else if (pick < 90)
          send_word(OP_WRITE_RIGHT, row, col, pick_value());
        else
          send_word(OP_UNUSED, row, col, $urandom);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    operation_i     = OP_WRITE_LEFT;
    row_index_i     = '0;
    column_index_i  = '0;
    element_value_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    size_cfg        = SIZE_RESET;
    error_count     = 0;
    words_sent      = 0;
    no_idle         = 1'b0;
    for (int i = 0; i < 4096; i++) begin
      left_store[i]    = 0;
      right_store[i]   = 0;
      left_written[i]  = 1'b0;
      right_written[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_extreme_elements();
    test_unused_operation();
    test_sum_wraparound();
    test_size_zero();
    test_size_saturation();
    test_random_traffic();

    drain_and_settle();
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
